/* rtl/rlim_pkg.sv */
`default_nettype none

package rlim_pkg;

    // Table geometry.
    localparam int TableEntries = 64;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

    // Field widths and limits.
    localparam int CfgW = 16;
    localparam int CountW = 17;
    localparam int RemovedW = 7;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [RemovedW-1:0] RemovedMax = '1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MAX_CONNECTIONS = 1'b0,
        CFG_WINDOW_SECONDS  = 1'b1
    } t_cfg_idx;

    // One input beat.
    typedef struct packed {
        logic        mode;
        logic [31:0] source_address;
        logic [31:0] now_seconds;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic                rejected;
        logic                untracked;
        logic [RemovedW-1:0] removed_entries;
    } t_out_item;

    // One table entry as kept in memory.
    typedef struct packed {
        logic [31:0]       key;
        logic [CountW-1:0] count;
        logic [31:0]       start;
    } t_entry;

    // Status from the shared compare unit.
    typedef struct packed {
        logic expired;
        logic key_eq;
    } t_cmp_res;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE      = 2'd0,
        S_SWEEP_CHK = 2'd1,
        S_SCAN      = 2'd2,
        S_UPDATE    = 2'd3
    } t_state;

endpackage

`default_nettype wire

/* rtl/rlim_mem.sv */
`default_nettype none

module rlim_mem
    import rlim_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IdxW-1:0] i_waddr,
    input  wire t_entry          i_wdata,
    input  wire logic [IdxW-1:0] i_raddr,
    output t_entry               o_rdata
);

    // Entry storage: one write port, one registered read port.
    t_entry r_mem [TableEntries];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/rlim_cmp.sv */
`default_nettype none

module rlim_cmp
    import rlim_pkg::*;
(
    input  wire logic [31:0]     i_now,
    input  wire logic [31:0]     i_start_time,
    input  wire logic [CfgW-1:0] i_window,
    input  wire logic [31:0]     i_key,
    input  wire logic [31:0]     i_addr,
    output t_cmp_res             o_res
);

    logic [31:0] age;

    // Age of a window modulo 2^32, and the expiry compare against the window length.
    assign age = i_now - i_start_time;
    assign o_res.expired = age > {16'd0, i_window};

    // Key match for the lookup.
    assign o_res.key_eq = i_key == i_addr;

endmodule

`default_nettype wire

/* rtl/per_address_connection_rate_limiter.sv */
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-------------------------------------
// input     | i_item (mode, source_address, now)     | start high while busy low
// result    | o_result (rejected, untracked, removed)| o_done high for one cycle
// config    | i_cfg_we, i_cfg_idx, i_cfg_data        | i_cfg_we high, written at once
//
// A check with limiting disabled answers in the cycle after it is taken.
// A check walks the table one entry per cycle through the entry memory's read port,
// stops at the first hit or at the last entry, and answers from the update step.
// A sweep first tests the sweep interval and, when it is due, walks the whole table.
// Reset is synchronous; it clears the valid bits at once, so no clearing pass follows.
// Results cannot be stalled: each is shown for exactly one cycle.
`default_nettype none

module per_address_connection_rate_limiter
    import rlim_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire t_in_item        i_item,
    output logic                 o_done,
    output t_out_item            o_result,
    input  wire logic            i_cfg_we,
    input  wire t_cfg_idx        i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data
);

    // Configuration and persistent state.
    logic [CfgW-1:0]         r_max;
    logic [CfgW-1:0]         r_win;
    logic [TableEntries-1:0] r_valid;
    logic [31:0]             r_last_sweep;

    // Item held for the whole operation.
    logic        r_mode;
    logic [31:0] r_addr;
    logic [31:0] r_now;

    // Scan pipeline: read issue and evaluation stage.
    logic            r_issue;
    logic [IdxW-1:0] r_idx;
    logic            r_ev_act;
    logic [IdxW-1:0] r_ev_idx;

    // Lookup outcome.
    logic            r_hit;
    logic [IdxW-1:0] r_hit_idx;
    t_entry          r_ent;
    logic            r_free_found;
    logic [IdxW-1:0] r_free_idx;

    // Sweep bookkeeping.
    logic [RemovedW-1:0] r_removed;
    logic                r_any;

    // Result register.
    logic      r_done;
    t_out_item r_out;

    t_state r_state;
    t_state n_state;

    // Combinational control.
    logic                accept;
    logic                disabled;
    logic                ev_valid;
    logic                hit;
    logic                scan_end;
    logic                sweep_free;
    logic [RemovedW-1:0] removed_nxt;
    logic [31:0]         cmp_operand;
    logic                mem_we;
    logic [IdxW-1:0]     mem_waddr;
    t_entry              mem_wdata;
    t_entry              mem_rdata;
    t_cmp_res            cmp;
    logic [CountW-1:0]   count_inc;
    logic                in_window;

    // Entry memory.
    rlim_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // Shared expiry and key compare unit.
    rlim_cmp u_cmp (
        .i_now        (r_now),
        .i_start_time (cmp_operand),
        .i_window     (r_win),
        .i_key        (mem_rdata.key),
        .i_addr       (r_addr),
        .o_res        (cmp)
    );

    assign busy     = r_state != S_IDLE;
    assign accept   = start && !busy;
    assign disabled = (r_max == '0) || (r_win == '0);
    assign ev_valid = r_valid[r_ev_idx];
    assign hit      = (r_state == S_SCAN) && r_ev_act && !r_mode && ev_valid && cmp.key_eq;
    assign scan_end = (r_state == S_SCAN) && r_ev_act && (r_ev_idx == LastIdx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.mode) begin
                        n_state = S_SWEEP_CHK;
                    end else if (!disabled) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SWEEP_CHK: begin
                n_state = cmp.expired ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (!r_mode && (hit || scan_end)) begin
                    n_state = S_UPDATE;
                end else if (r_mode && scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Compare operand per state.
    always_comb begin
        cmp_operand = r_ent.start;
        unique case (r_state)
            S_SWEEP_CHK: cmp_operand = r_last_sweep;
            S_SCAN:      cmp_operand = mem_rdata.start;
            S_IDLE,
            S_UPDATE:    cmp_operand = r_ent.start;
            default:     cmp_operand = r_ent.start;
        endcase
    end

    // Sweep: freeing decision and saturating count for the entry under evaluation.
    assign sweep_free  = (r_state == S_SCAN) && r_ev_act && r_mode && ev_valid && cmp.expired;
    assign removed_nxt = (sweep_free && (r_removed != RemovedMax)) ? r_removed + 1'b1
                                                                    : r_removed;

    // Check update: saturating increment within the window, fresh window otherwise.
    assign count_inc = (r_ent.count == CountMax) ? r_ent.count : r_ent.count + 1'b1;
    assign in_window = r_hit && !cmp.expired;

    assign mem_we          = (r_state == S_UPDATE) && (r_hit || r_free_found);
    assign mem_waddr       = r_hit ? r_hit_idx : r_free_idx;
    assign mem_wdata.key   = r_addr;
    assign mem_wdata.count = in_window ? count_inc : CountW'(1);
    assign mem_wdata.start = in_window ? r_ent.start : r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= '0;
            r_win        <= '0;
            r_valid      <= '0;
            r_last_sweep <= '0;
            r_issue      <= 1'b0;
            r_ev_act     <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_CONNECTIONS: r_max <= i_cfg_data;
                    CFG_WINDOW_SECONDS:  r_win <= i_cfg_data;
                    default:             r_max <= r_max;
                endcase
            end

            // Read issue: one entry address per cycle.
            if (r_issue) begin
                r_ev_act <= 1'b1;
                r_ev_idx <= r_idx;
                if (r_idx == LastIdx) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_ev_act <= 1'b0;
            end

            // Take a new beat.
            if (accept) begin
                r_mode       <= i_item.mode;
                r_addr       <= i_item.source_address;
                r_now        <= i_item.now_seconds;
                r_idx        <= '0;
                r_issue      <= !i_item.mode && !disabled;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_removed    <= '0;
                r_any        <= 1'b0;
                if (!i_item.mode && disabled) begin
                    r_done <= 1'b1;
                    r_out  <= '0;
                end
            end

            // Sweep interval test.
            if (r_state == S_SWEEP_CHK) begin
                if (cmp.expired) begin
                    r_issue <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                    r_out  <= '0;
                end
            end

            // Lookup evaluation.
            if ((r_state == S_SCAN) && r_ev_act && !r_mode) begin
                if (!ev_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_ev_idx;
                end
                if (hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_ev_idx;
                    r_ent     <= mem_rdata;
                    r_issue   <= 1'b0;
                    r_ev_act  <= 1'b0;
                end
            end

            // Sweep evaluation.
            if ((r_state == S_SCAN) && r_ev_act && r_mode) begin
                r_removed <= removed_nxt;
                if (ev_valid) begin
                    r_any <= 1'b1;
                end
                if (sweep_free) begin
                    r_valid[r_ev_idx] <= 1'b0;
                end
                if (scan_end) begin
                    r_done                   <= 1'b1;
                    r_out.rejected           <= 1'b0;
                    r_out.untracked          <= 1'b0;
                    r_out.removed_entries    <= removed_nxt;
                    if (r_any || ev_valid) begin
                        r_last_sweep <= r_now;
                    end
                end
            end

            // Check result and table update.
            if (r_state == S_UPDATE) begin
                r_done                <= 1'b1;
                r_out.rejected        <= in_window && (count_inc > {1'b0, r_max});
                r_out.untracked       <= !r_hit && !r_free_found;
                r_out.removed_entries <= '0;
                if (!r_hit && r_free_found) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // An accepted beat either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("accepted beat neither answered nor started");

    // A result only appears once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while sequencer active");

    // A sweep result never flags a connection.
    a_sweep_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.removed_entries != '0)) |->
            (!o_result.rejected && !o_result.untracked))
        else $error("sweep result carries check flags");

    // Reads are only issued during a scan.
    a_issue_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> ((r_state == S_SCAN) || (r_state == S_SWEEP_CHK)
                     || $past(accept)))
        else $error("table read issued outside a scan");

    // A lookup hit always leads to the update step.
    a_hit_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> (r_state == S_UPDATE))
        else $error("lookup hit did not reach the update step");

endmodule

`default_nettype wire
